FILE: rtl/cba_pkg.sv
// Package with the shared constants, register codes and control structs of the accumulator.
package cba_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int COORD_W  = 16;
  localparam int COEF_W   = 32;
  localparam int COUNTS_W = 16;
  localparam int SUM_W    = 32;
  localparam int ACC_W    = 32;
  localparam int SLOT_W   = 2;

  localparam int PROD_W    = COEF_W + COORD_W;
  localparam int VACC_W    = PROD_W + 3;
  localparam int DIVD_W    = COUNTS_W + 2 * FRACTION_BITS;
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int QEXT_W    = (DIVD_W > ACC_W + 2) ? DIVD_W : ACC_W + 2;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_VOXEL_X     = 2'd0,
    REG_VOXEL_Y     = 2'd1,
    REG_VOXEL_Z     = 2'd2,
    REG_START_COEF  = 2'd3
  } reg_idx_t;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_LEFT  = 2'd0,
    SLOT_RIGHT = 2'd1,
    SLOT_FRONT = 2'd2,
    SLOT_BACK  = 2'd3
  } slot_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic [SLOT_W-1:0] mul_sel;
    logic              add_en;
    logic              div_start;
    logic              div_step;
    logic              acc_update;
    logic              emit;
  } dp_cmd_t;

  typedef struct packed {
    logic  below;
    logic  sum_nz;
    slot_t slot;
    logic  last;
  } dp_sts_t;

endpackage

FILE: rtl/cba_dp.sv
// Datapath: configuration registers, shared plane multiplier, restoring divider and accumulator.
module cba_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr,
  input  cba_pkg::reg_idx_t                   cfg_idx,
  input  logic [cba_pkg::APB_DATA_W-1:0]      cfg_wdata,
  output logic [cba_pkg::APB_DATA_W-1:0]      cfg_rdata,
  input  logic [cba_pkg::SLOT_W-1:0]          in_plane_slot,
  input  logic signed [cba_pkg::COEF_W-1:0]   in_coef_a,
  input  logic signed [cba_pkg::COEF_W-1:0]   in_coef_b,
  input  logic signed [cba_pkg::COEF_W-1:0]   in_coef_c,
  input  logic signed [cba_pkg::COEF_W-1:0]   in_plane_offset,
  input  logic [cba_pkg::COUNTS_W-1:0]        in_event_counts,
  input  logic [cba_pkg::SUM_W-1:0]           in_event_sum,
  input  logic                                in_last_event,
  input  cba_pkg::dp_cmd_t                    cmd,
  output cba_pkg::dp_sts_t                    sts,
  output logic signed [cba_pkg::ACC_W-1:0]    out_data
);

  logic signed [cba_pkg::COORD_W-1:0]  vox_x_r, vox_y_r, vox_z_r;
  logic signed [cba_pkg::ACC_W-1:0]    start_r;
  logic signed [cba_pkg::ACC_W-1:0]    acc_r;
  logic signed [cba_pkg::ACC_W-1:0]    out_r;

  logic [cba_pkg::SLOT_W-1:0]          slot_r;
  logic signed [cba_pkg::COEF_W-1:0]   a_r, b_r, c_r;
  logic [cba_pkg::COUNTS_W-1:0]        counts_r;
  logic [cba_pkg::SUM_W-1:0]           sum_r;
  logic                                last_r;

  logic signed [cba_pkg::PROD_W-1:0]   prod_r;
  logic signed [cba_pkg::VACC_W-1:0]   vacc_r;
  logic [cba_pkg::SUM_W-1:0]           rem_r;
  logic [cba_pkg::DIVD_W-1:0]          divq_r;

  logic signed [cba_pkg::COEF_W-1:0]   mul_a;
  logic signed [cba_pkg::COORD_W-1:0]  mul_b;
  logic [cba_pkg::SUM_W:0]             trial;
  logic                                trial_ge;
  logic [cba_pkg::QEXT_W-1:0]          q_ext;
  logic [cba_pkg::ACC_W:0]             q_clamp;
  logic signed [cba_pkg::ACC_W+1:0]    acc_sum;
  logic signed [cba_pkg::ACC_W-1:0]    acc_sat;

  always_comb begin
    case (cba_pkg::slot_t'(cmd.mul_sel))
      cba_pkg::SLOT_LEFT:  begin mul_a = a_r; mul_b = vox_x_r; end
      cba_pkg::SLOT_RIGHT: begin mul_a = b_r; mul_b = vox_y_r; end
      default:             begin mul_a = c_r; mul_b = vox_z_r; end
    endcase
  end

  // One quotient bit per step; the remainder always stays below the divisor.
  assign trial    = {rem_r, divq_r[cba_pkg::DIVD_W-1]};
  assign trial_ge = trial >= {1'b0, sum_r};

  // Quotients above 2^32 are clamped before the saturating add.
  assign q_ext   = cba_pkg::QEXT_W'(divq_r);
  assign q_clamp = (q_ext > cba_pkg::QEXT_W'({1'b1, {cba_pkg::ACC_W{1'b0}}}))
                   ? {1'b1, {cba_pkg::ACC_W{1'b0}}}
                   : q_ext[cba_pkg::ACC_W:0];
  assign acc_sum = (cba_pkg::ACC_W+2)'(acc_r) + $signed({1'b0, q_clamp});
  assign acc_sat = (acc_sum > $signed((cba_pkg::ACC_W+2)'({1'b0, {(cba_pkg::ACC_W-1){1'b1}}})))
                   ? {1'b0, {(cba_pkg::ACC_W-1){1'b1}}}
                   : acc_sum[cba_pkg::ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vox_x_r <= '0;
      vox_y_r <= '0;
      vox_z_r <= '0;
      start_r <= '0;
      acc_r   <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          cba_pkg::REG_VOXEL_X:    vox_x_r <= cfg_wdata[cba_pkg::COORD_W-1:0];
          cba_pkg::REG_VOXEL_Y:    vox_y_r <= cfg_wdata[cba_pkg::COORD_W-1:0];
          cba_pkg::REG_VOXEL_Z:    vox_z_r <= cfg_wdata[cba_pkg::COORD_W-1:0];
          cba_pkg::REG_START_COEF: begin
            start_r <= cfg_wdata[cba_pkg::ACC_W-1:0];
            acc_r   <= cfg_wdata[cba_pkg::ACC_W-1:0];
          end
          default: ;
        endcase
      end
      if (cmd.acc_update) begin
        acc_r <= acc_sat;
      end
      if (cmd.emit) begin
        acc_r <= start_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r   <= in_plane_slot;
      a_r      <= in_coef_a;
      b_r      <= in_coef_b;
      c_r      <= in_coef_c;
      counts_r <= in_event_counts;
      sum_r    <= in_event_sum;
      last_r   <= in_last_event;
      vacc_r   <= -cba_pkg::VACC_W'(in_plane_offset);
    end else if (cmd.add_en) begin
      vacc_r <= vacc_r + cba_pkg::VACC_W'(prod_r);
    end
    if (cmd.mul_en) begin
      prod_r <= cba_pkg::PROD_W'(mul_a) * cba_pkg::PROD_W'(mul_b);
    end
    if (cmd.div_start) begin
      rem_r  <= '0;
      divq_r <= {counts_r, {(2 * cba_pkg::FRACTION_BITS){1'b0}}};
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? cba_pkg::SUM_W'(trial - {1'b0, sum_r}) : trial[cba_pkg::SUM_W-1:0];
      divq_r <= {divq_r[cba_pkg::DIVD_W-2:0], trial_ge};
    end
    if (cmd.emit) begin
      out_r <= acc_r;
    end
  end

  always_comb begin
    case (cfg_idx)
      cba_pkg::REG_VOXEL_X: cfg_rdata = cba_pkg::APB_DATA_W'(vox_x_r);
      cba_pkg::REG_VOXEL_Y: cfg_rdata = cba_pkg::APB_DATA_W'(vox_y_r);
      cba_pkg::REG_VOXEL_Z: cfg_rdata = cba_pkg::APB_DATA_W'(vox_z_r);
      default:              cfg_rdata = cba_pkg::APB_DATA_W'(start_r);
    endcase
  end

  assign sts.below  = vacc_r[cba_pkg::VACC_W-1] || (vacc_r == '0);
  assign sts.sum_nz = (sum_r != '0);
  assign sts.slot   = cba_pkg::slot_t'(slot_r);
  assign sts.last   = last_r;
  assign out_data   = out_r;

endmodule

FILE: rtl/cba_ctrl.sv
// Controller: sequences the multiply, compare, divide and update steps of each plane word.
module cba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  cba_pkg::dp_sts_t   sts,
  output cba_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_EVAL,
    S_DIV,
    S_UPD,
    S_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  logic [cba_pkg::SLOT_W-1:0]      step_r, step_nxt;
  logic [cba_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            inside_r, inside_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            new_inside;

  assign new_inside = (sts.slot == cba_pkg::SLOT_LEFT) ? sts.below : (inside_r && sts.below);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    inside_nxt    = inside_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en  = (step_r != cba_pkg::SLOT_W'(3));
        cmd.mul_sel = step_r;
        cmd.add_en  = (step_r != '0);
        step_nxt    = step_r + 1'b1;
        if (step_r == cba_pkg::SLOT_W'(3)) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.slot != cba_pkg::SLOT_BACK) begin
          inside_nxt = new_inside;
          state_nxt  = S_IDLE;
        end else begin
          inside_nxt = 1'b1;
          if (new_inside && sts.sum_nz) begin
            cmd.div_start = 1'b1;
            cnt_nxt       = '0;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == cba_pkg::DIV_CNT_W'(cba_pkg::DIVD_W - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.acc_update = 1'b1;
        state_nxt      = S_FIN;
      end
      S_FIN: begin
        if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (!(out_valid_r && out_stall)) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      inside_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      inside_r    <= inside_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // No word is taken while reset is held.
  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/cone_backprojection_accumulator_unit.sv
// Top level of the per-voxel cone backprojection accumulator.
// The block takes one plane word at a time: for each word it forms a*x + b*y + c*z - d
// exactly with a single shared 32x16 multiplier (three products in turn) and
// decides whether the voxel lies on the inner side of that plane. Four words (left,
// right, front, back) make one event; a left word starts a new inside test. On a back
// word whose event contains the voxel and has a nonzero sum, a restoring divider forms
// (counts << 2*FRACTION_BITS) / sum one quotient bit per cycle, and the clamped
// quotient is added to the saturating Q16.16 accumulator. A back word flagged as the
// last event places the accumulator in the output register and reloads it from the
// start coefficient. Each word passes the multiply and compare steps; a back word
// goes on to a finish step, with the divider steps and an update step in between
// when it divides. A finished result, a Q16.16 word, waits in the output register
// while the next words are already taken; only a second result stalls behind it.
// Writing the start coefficient also reloads the accumulator. Registers sit at byte
// addresses 0 (voxel x), 4 (voxel y), 8 (voxel z) and 12 (start coefficient); they
// are to be written only while the block is idle, which the block does not enforce.
module cone_backprojection_accumulator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cba_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [cba_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [cba_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cba_pkg::SLOT_W-1:0]           in_plane_slot,
  input  logic signed [cba_pkg::COEF_W-1:0]    in_coef_a,
  input  logic signed [cba_pkg::COEF_W-1:0]    in_coef_b,
  input  logic signed [cba_pkg::COEF_W-1:0]    in_coef_c,
  input  logic signed [cba_pkg::COEF_W-1:0]    in_plane_offset,
  input  logic [cba_pkg::COUNTS_W-1:0]         in_event_counts,
  input  logic [cba_pkg::SUM_W-1:0]            in_event_sum,
  input  logic                                 in_last_event,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cba_pkg::ACC_W-1:0]     out_adjusted_coefficient
);

  cba_pkg::dp_cmd_t  cmd;
  cba_pkg::dp_sts_t  sts;
  logic              cfg_wr;
  cba_pkg::reg_idx_t cfg_idx;

  // The port never inserts wait states, so a write lands in its access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cba_pkg::reg_idx_t'(paddr[cba_pkg::APB_ADDR_W-1:2]);

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cba_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr          (cfg_wr),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (pwdata),
    .cfg_rdata       (prdata),
    .in_plane_slot   (in_plane_slot),
    .in_coef_a       (in_coef_a),
    .in_coef_b       (in_coef_b),
    .in_coef_c       (in_coef_c),
    .in_plane_offset (in_plane_offset),
    .in_event_counts (in_event_counts),
    .in_event_sum    (in_event_sum),
    .in_last_event   (in_last_event),
    .cmd             (cmd),
    .sts             (sts),
    .out_data        (out_adjusted_coefficient)
  );

endmodule

FILE: rtl/cba_checker.sv
// Port-level checker for the accumulator and its bind to the top level.
module cba_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           pready,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [cba_pkg::ACC_W-1:0]      out_adjusted_coefficient
);

  // Reset leaves no result word pending.
  a_reset_clears_out: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result word valid right after reset");

  // The block works on one plane word at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new plane word taken while the previous one is in progress");

  // A new result only appears at the end of a word's processing.
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared without a word in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_adjusted_coefficient))
    else $error("stalled result word changed or dropped");

  a_no_wait_states: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("register port inserted a wait state");

endmodule

bind cone_backprojection_accumulator_unit cba_checker u_cba_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .pready                   (pready),
  .in_valid                 (in_valid),
  .in_stall                 (in_stall),
  .out_valid                (out_valid),
  .out_stall                (out_stall),
  .out_adjusted_coefficient (out_adjusted_coefficient)
);

FILE: bench/tb_top.sv
// Self-checking testbench for the cone backprojection accumulator unit.
`timescale 1ns / 1ps

module tb_top;

  // The quiet stretch after the last expected result outlasts any word that takes
  // the divider, so it guarantees that no earlier word is still in flight.
  localparam int QUIET_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int WORDS_PER_SET  = 225;

  localparam longint I32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint I32_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam longint unsigned QUO_CAP = 64'h0000_0001_0000_0000;

  // One plane word as it travels on the input channel.
  typedef struct packed {
    cba_pkg::slot_t                     slot;
    logic signed [cba_pkg::COEF_W-1:0]  a;
    logic signed [cba_pkg::COEF_W-1:0]  b;
    logic signed [cba_pkg::COEF_W-1:0]  c;
    logic signed [cba_pkg::COEF_W-1:0]  d;
    logic [cba_pkg::COUNTS_W-1:0]       counts;
    logic [cba_pkg::SUM_W-1:0]          ev_sum;
    logic                               last;
  } plane_word_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [cba_pkg::APB_ADDR_W-1:0]     paddr;
  logic [cba_pkg::APB_DATA_W-1:0]     pwdata;
  logic [cba_pkg::APB_DATA_W-1:0]     prdata;
  logic                               pready;

  logic                               in_valid;
  logic                               in_stall;
  logic [cba_pkg::SLOT_W-1:0]         in_plane_slot;
  logic signed [cba_pkg::COEF_W-1:0]  in_coef_a;
  logic signed [cba_pkg::COEF_W-1:0]  in_coef_b;
  logic signed [cba_pkg::COEF_W-1:0]  in_coef_c;
  logic signed [cba_pkg::COEF_W-1:0]  in_plane_offset;
  logic [cba_pkg::COUNTS_W-1:0]       in_event_counts;
  logic [cba_pkg::SUM_W-1:0]          in_event_sum;
  logic                               in_last_event;
  logic                               out_valid;
  logic                               out_stall;
  logic signed [cba_pkg::ACC_W-1:0]   out_adjusted_coefficient;

  // Shadow of the voxel registers and the accumulator state, kept in step with
  // every accepted word and every register write.
  logic signed [cba_pkg::COORD_W-1:0] vox_x = '0;
  logic signed [cba_pkg::COORD_W-1:0] vox_y = '0;
  logic signed [cba_pkg::COORD_W-1:0] vox_z = '0;
  logic signed [cba_pkg::ACC_W-1:0]   start_coef = '0;
  logic signed [cba_pkg::ACC_W-1:0]   acc = '0;
  logic                               in_region = 1'b1;

  // Coefficients that the block owes us, oldest first.
  logic signed [cba_pkg::ACC_W-1:0]   expected_coefs[$];

  int  mismatches   = 0;
  int  quiet_cycles = 0;
  bit  tx_idle_on   = 1'b1;
  bit  rx_stall_on  = 1'b1;

  cone_backprojection_accumulator_unit dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .psel                     (psel),
    .penable                  (penable),
    .pwrite                   (pwrite),
    .paddr                    (paddr),
    .pwdata                   (pwdata),
    .prdata                   (prdata),
    .pready                   (pready),
    .in_valid                 (in_valid),
    .in_stall                 (in_stall),
    .in_plane_slot            (in_plane_slot),
    .in_coef_a                (in_coef_a),
    .in_coef_b                (in_coef_b),
    .in_coef_c                (in_coef_c),
    .in_plane_offset          (in_plane_offset),
    .in_event_counts          (in_event_counts),
    .in_event_sum             (in_event_sum),
    .in_last_event            (in_last_event),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_adjusted_coefficient (out_adjusted_coefficient)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gap lengths: usually none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [cba_pkg::COEF_W-1:0] small_coef();
    return cba_pkg::COEF_W'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
  endfunction

  function automatic plane_word_t plane_word(input cba_pkg::slot_t s, input logic [31:0] a,
                                             input logic [31:0] b, input logic [31:0] c,
                                             input logic [31:0] d, input logic [15:0] counts,
                                             input logic [31:0] ev_sum, input logic last);
    plane_word_t w;
    w.slot   = s;
    w.a      = a;
    w.b      = b;
    w.c      = c;
    w.d      = d;
    w.counts = counts;
    w.ev_sum = ev_sum;
    w.last   = last;
    return w;
  endfunction

  // Builds a plane word with random coefficients. The offset is mostly chosen so
  // that the voxel lies on the inner side of the plane, since only events that
  // contain the voxel ever reach the divider; a share of words lands exactly on
  // the plane, just outside it, or anywhere.
  function automatic plane_word_t make_plane(input cba_pkg::slot_t s, input logic last_flag);
    plane_word_t w;
    longint      p;
    int          r;
    w.slot = s;
    w.a    = $urandom_range(0, 1) ? cba_pkg::COEF_W'($urandom) : small_coef();
    w.b    = $urandom_range(0, 1) ? cba_pkg::COEF_W'($urandom) : small_coef();
    w.c    = $urandom_range(0, 1) ? cba_pkg::COEF_W'($urandom) : small_coef();
    p = longint'($signed(w.a)) * longint'(vox_x) + longint'($signed(w.b)) * longint'(vox_y)
      + longint'($signed(w.c)) * longint'(vox_z);
    r = $urandom_range(0, 99);
    if (p < I32_MIN || p > I32_MAX) begin
      w.d = $urandom;
    end else if (r < 80) begin
      p = p + longint'($urandom_range(0, 4095));
      if (p > I32_MAX) p = I32_MAX;
      w.d = p[31:0];
    end else if (r < 88) begin
      w.d = p[31:0];
    end else if (r < 94 && p > I32_MIN) begin
      w.d = 32'(p - 1);
    end else begin
      w.d = $urandom;
    end
    w.counts = cba_pkg::COUNTS_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) w.ev_sum = '0;
    else if (r < 20) w.ev_sum = $urandom_range(1, 255);
    else w.ev_sum = $urandom;
    w.last = (s == cba_pkg::SLOT_BACK) ? last_flag : logic'($urandom_range(0, 1));
    return w;
  endfunction

  // Advances the shadow state by one accepted plane word. A left word restarts
  // the inside test, the others narrow it, and a back word applies the update,
  // reopens the test and, on the last event, yields the coefficient.
  task automatic accumulate_plane(input plane_word_t w);
    longint          v;
    logic            below;
    longint unsigned num;
    longint unsigned quo;
    longint          total;
    v = longint'($signed(w.a)) * longint'(vox_x) + longint'($signed(w.b)) * longint'(vox_y)
      + longint'($signed(w.c)) * longint'(vox_z) - longint'($signed(w.d));
    below = (v <= 0);
    if (w.slot == cba_pkg::SLOT_LEFT) in_region = below;
    else in_region = in_region & below;
    if (w.slot == cba_pkg::SLOT_BACK) begin
      if (in_region && w.ev_sum != 0) begin
        num = 64'(w.counts) << (2 * cba_pkg::FRACTION_BITS);
        quo = num / 64'(w.ev_sum);
        if (quo > QUO_CAP) quo = QUO_CAP;
        total = longint'(acc) + longint'(quo);
        if (total > I32_MAX) total = I32_MAX;
        acc = total[31:0];
      end
      in_region = 1'b1;
      if (w.last) begin
        expected_coefs.push_back(acc);
        acc = start_coef;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch (%s): got %h, want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Register write: setup cycle, then access cycle; the shadow copy follows at
  // the edge where the block takes the data.
  task automatic cfg_write(input cba_pkg::reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      cba_pkg::REG_VOXEL_X: vox_x = value[cba_pkg::COORD_W-1:0];
      cba_pkg::REG_VOXEL_Y: vox_y = value[cba_pkg::COORD_W-1:0];
      cba_pkg::REG_VOXEL_Z: vox_z = value[cba_pkg::COORD_W-1:0];
      cba_pkg::REG_START_COEF: begin
        start_coef = value;
        acc        = value;
      end
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_voxel(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                           input logic [31:0] start);
    cfg_write(cba_pkg::REG_VOXEL_X, x);
    cfg_write(cba_pkg::REG_VOXEL_Y, y);
    cfg_write(cba_pkg::REG_VOXEL_Z, z);
    cfg_write(cba_pkg::REG_START_COEF, start);
  endtask

  // Offers one word and holds it until accepted. With a zero gap valid stays
  // high, so the next call must follow at once or the caller must drop valid.
  task automatic send_word(input plane_word_t w);
    int gap;
    @(negedge clk);
    in_valid        = 1'b1;
    in_plane_slot   = w.slot;
    in_coef_a       = w.a;
    in_coef_b       = w.b;
    in_coef_c       = w.c;
    in_plane_offset = w.d;
    in_event_counts = w.counts;
    in_event_sum    = w.ev_sum;
    in_last_event   = w.last;
    do @(posedge clk); while (in_stall);
    accumulate_plane(w);
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // A full event; skip_slot drops one plane to form a broken sequence.
  task automatic send_event(input logic last_flag, input int skip_slot);
    int s;
    for (s = 0; s < 4; s++) begin
      if (s != skip_slot) send_word(make_plane(cba_pkg::slot_t'(s), last_flag));
    end
  endtask

  // Stops sending, waits for every owed coefficient, then lets any word that
  // produces no result finish inside the block.
  task automatic drain_then_rest();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_coefs.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Plane rules at the reset setting, where the voxel sits at the origin and the
  // plane value is simply -d.
  task automatic test_plane_rules();
    // Boundary, far inside and just inside; fields that only the back plane uses
    // carry junk on the other planes. Expect exactly 1.0.
    send_word(plane_word(cba_pkg::SLOT_LEFT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                         32'h0, 16'hFFFF, 32'h0, 1'b1));
    send_word(plane_word(cba_pkg::SLOT_RIGHT, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF,
                         16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    send_word(plane_word(cba_pkg::SLOT_FRONT, 32'h0, 32'h0, 32'h0, 32'h1,
                         16'h1234, 32'h5, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_BACK, 32'h0, 32'h0, 32'h0, 32'h0,
                         16'h1, 32'h0001_0000, 1'b1));
    // Front plane one step outside: the event must not add anything.
    send_word(plane_word(cba_pkg::SLOT_LEFT, 32'h0, 32'h0, 32'h0, 32'h5,
                         16'h0, 32'h0, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_RIGHT, 32'h0, 32'h0, 32'h0, 32'h5,
                         16'h0, 32'h0, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_FRONT, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
                         16'h0, 32'h0, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_BACK, 32'h0, 32'h0, 32'h0, 32'h5,
                         16'hFFFF, 32'h1, 1'b1));
    // A lone back word with a zero sum: inside, but no division takes place.
    send_word(plane_word(cba_pkg::SLOT_BACK, 32'h0, 32'h0, 32'h0, 32'h0,
                         16'hFFFF, 32'h0, 1'b1));
    // An outside right word is forgotten once a left word starts a new event;
    // the huge quotient is clamped and the sum saturates.
    send_word(plane_word(cba_pkg::SLOT_RIGHT, 32'h0, 32'h0, 32'h0, 32'h8000_0000,
                         16'h0, 32'h0, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_LEFT, 32'h0, 32'h0, 32'h0, 32'h0,
                         16'h0, 32'h0, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_BACK, 32'h0, 32'h0, 32'h0, 32'h0,
                         16'hFFFF, 32'h1, 1'b1));
    drain_then_rest();
  endtask

  // Extreme coordinates and coefficients, and the start coefficient at both ends.
  task automatic test_register_extremes();
    set_voxel(32'hFFFF_8000, 32'h0000_7FFF, 32'hFFFF_8000, 32'h8000_0000);
    // Every product is near its largest magnitude and negative, so the voxel is
    // inside; the quotient is just under one and lands on the most negative start.
    send_word(plane_word(cba_pkg::SLOT_LEFT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 16'h0, 32'h0, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_RIGHT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 16'h0, 32'h0, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_FRONT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 16'h0, 32'h0, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_BACK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    drain_then_rest();
    cfg_write(cba_pkg::REG_START_COEF, 32'h7FFF_0000);
    // The left plane puts the voxel far outside; the back word alone cannot undo it.
    send_word(plane_word(cba_pkg::SLOT_LEFT, 32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF,
                         16'h0, 32'h0, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_BACK, 32'h0, 32'h0, 32'h0, 32'h0,
                         16'h1, 32'h1, 1'b1));
    // Next event starts inside and saturates at the top.
    send_word(plane_word(cba_pkg::SLOT_BACK, 32'h0, 32'h0, 32'h0, 32'h0,
                         16'h1, 32'h1, 1'b1));
    drain_then_rest();
    cfg_write(cba_pkg::REG_START_COEF, 32'h0);
    // Two events add up before the last one reports: expect 2.0.
    send_word(plane_word(cba_pkg::SLOT_BACK, 32'h0, 32'h0, 32'h0, 32'h0,
                         16'h1, 32'h0001_0000, 1'b0));
    send_word(plane_word(cba_pkg::SLOT_BACK, 32'h0, 32'h0, 32'h0, 32'h0,
                         16'h1, 32'h0001_0000, 1'b1));
    drain_then_rest();
  endtask

  // Random traffic over several voxel settings. Most traffic is complete events;
  // the rest is events with a missing plane and stray words of any kind.
  task automatic test_random_events();
    int set_no;
    int words;
    int events;
    int r;
    for (set_no = 0; set_no < 4; set_no++) begin
      drain_then_rest();
      case (set_no)
        0: set_voxel(32'($urandom_range(0, 16)) - 32'd8, 32'($urandom_range(0, 16)) - 32'd8,
                     32'($urandom_range(0, 16)) - 32'd8, 32'($urandom_range(0, 32'h0010_0000)));
        1: set_voxel(32'($urandom_range(0, 512)) - 32'd256,
                     32'($urandom_range(0, 512)) - 32'd256,
                     32'($urandom_range(0, 512)) - 32'd256, $urandom);
        2: set_voxel($urandom, $urandom, $urandom, 32'h7FF0_0000);
        default: set_voxel(32'h0000_7FFF, 32'hFFFF_8000, 32'h0000_7FFF, 32'h8000_0000);
      endcase
      words  = 0;
      events = 0;
      while (words < WORDS_PER_SET) begin
        // Switch sender idling and receiver stalls on and off now and then so that long runs without gaps occur.
        if (events % 16 == 0) begin
          tx_idle_on  = ($urandom_range(0, 3) != 0);
          rx_stall_on = ($urandom_range(0, 3) != 0);
        end
        events++;
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_event(logic'($urandom_range(0, 3) == 0), -1);
          words += 4;
        end else if (r < 90) begin
          send_event(logic'($urandom_range(0, 1)), $urandom_range(0, 3));
          words += 3;
        end else begin
          send_word(plane_word(cba_pkg::slot_t'($urandom_range(0, 3)), $urandom, $urandom,
                               $urandom, $urandom, 16'($urandom), $urandom,
                               logic'($urandom_range(0, 1))));
          words += 1;
        end
        // Occasionally hold the sender back until the block has caught up.
        if ($urandom_range(0, 39) == 0) drain_then_rest();
      end
    end
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  // Receiver: stall stretches of random length, applied at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      repeat (pick_gap() + 1) @(negedge clk);
      if (rx_stall_on) begin
        out_stall = 1'b1;
        repeat (pick_gap() + 1) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Every result the block hands over is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_coefs.size() == 0) begin
        report_mismatch("result with nothing expected", out_adjusted_coefficient, 32'h0);
      end else begin
        if (out_adjusted_coefficient !== expected_coefs[0]) begin
          report_mismatch("adjusted_coefficient", out_adjusted_coefficient, expected_coefs[0]);
        end
        void'(expected_coefs.pop_front());
      end
    end
  end

  // Watchdog: any handshake on the input or output channel, or any register write, counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pwrite)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    in_plane_slot   = '0;
    in_coef_a       = '0;
    in_coef_b       = '0;
    in_coef_c       = '0;
    in_plane_offset = '0;
    in_event_counts = '0;
    in_event_sum    = '0;
    in_last_event   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plane_rules();
    test_register_extremes();
    test_random_events();

    drain_then_rest();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
